// ===== rtl/kls_pkg.sv =====
package kls_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned K_W       = 10;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // Request fields are sized for the largest supported heap (65536 entries).
  localparam int unsigned REQ_LVL_W = 5;
  localparam int unsigned REQ_IDX_W = 16;

  // Register index decoded from paddr[2].
  localparam logic REG_K_RANK = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_WAIT,
    ST_POP,
    ST_POP_WAIT,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_DONE
  } kls_state_e;

  // One read and one write per cycle, broadcast along the row of level cells.
  typedef struct packed {
    logic                 rd_en;
    logic [REQ_LVL_W-1:0] rd_lvl;
    logic [REQ_IDX_W-1:0] rd_idx;
    logic                 wr_en;
    logic [REQ_LVL_W-1:0] wr_lvl;
    logic [REQ_IDX_W-1:0] wr_idx;
    logic [DATA_W-1:0]    wr_data;
  } kls_req_t;

endpackage

// ===== rtl/kls_ram.sv =====
module kls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kls_level_cell.sv =====
module kls_level_cell #(
  parameter int unsigned HEAP_DEPTH = 1024,
  parameter int unsigned LEVEL      = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kls_pkg::kls_req_t             req_i,
  input  logic [kls_pkg::DATA_W-1:0]    rdata_i,
  output logic [kls_pkg::DATA_W-1:0]    rdata_o
);

  // Entries of this heap level; the deepest level may be partly used.
  localparam int unsigned SPAN      = 1 << LEVEL;
  localparam int unsigned REMAIN    = HEAP_DEPTH - (SPAN - 1);
  localparam int unsigned NEED      = (SPAN < REMAIN) ? SPAN : REMAIN;
  localparam int unsigned RAM_DEPTH = (NEED < 2) ? 2 : NEED;
  localparam int unsigned AW        = $clog2(RAM_DEPTH);

  logic                       rd_hit;
  logic                       wr_hit;
  logic                       rd_sel_q;
  logic [kls_pkg::DATA_W-1:0] ram_rdata;

  assign rd_hit = req_i.rd_en && (req_i.rd_lvl == kls_pkg::REQ_LVL_W'(LEVEL));
  assign wr_hit = req_i.wr_en && (req_i.wr_lvl == kls_pkg::REQ_LVL_W'(LEVEL));

  kls_ram #(
    .WIDTH (kls_pkg::DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_hit),
    .waddr_i (req_i.wr_idx[AW-1:0]),
    .wdata_i (req_i.wr_data),
    .re_i    (rd_hit),
    .raddr_i (req_i.rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Remember which level answered the last read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_sel_q <= 1'b0;
    end else if (req_i.rd_en) begin
      rd_sel_q <= rd_hit;
    end
  end

  // Pass read data toward the root cell; this level inserts its own word.
  assign rdata_o = rd_sel_q ? ram_rdata : rdata_i;

endmodule

// ===== rtl/kth_largest_stream_tracker.sv =====
// kth_largest_stream_tracker keeps the k largest signed 32-bit values of a
// stream in a binary min-heap and returns, for every input transfer, one
// output transfer with the heap root (the k-th largest value seen) in tdata
// and a flag in tuser that is set once k values are held. k is the k_rank
// register at APB address 0 (reset 1); it saturates at HEAP_DEPTH - 1, a
// rank of zero keeps the heap empty and returns zero, and lowering it
// mid-stream does not trim the heap, since each item pops at most one
// entry, which only balances its own push. The heap is a row of level
// cells, one per tree level, each with its own RAM; read data travels from
// cell to cell toward the root. One item is worked at a time: the push
// sift-up reads the parent and writes the hole for each level climbed, and
// the pop fetches the last entry and then, for each level of sift-down,
// reads the children and decides, limited by the single read port of each
// level. An item finishes sooner when the new value settles early. The next
// item is taken while the last result still waits in the output register.
module kth_largest_stream_tracker #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kls_pkg::APB_AW-1:0]    paddr,
  input  logic [kls_pkg::APB_DW-1:0]    pwdata,
  output logic [kls_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [31:0] new_value
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] kth_value
  output logic [0:0]                    m_axis_tuser    // [0] holding_k
);

  localparam int unsigned LEVELS = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LW     = $clog2(LEVELS + 1);
  localparam int unsigned IW     = LEVELS - 1;
  localparam int unsigned CW     = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned PW     = CW + 2;
  localparam int unsigned KEW    = (CW > kls_pkg::K_W) ? CW : kls_pkg::K_W;
  localparam logic [CW-1:0] FULL = CW'(HEAP_DEPTH);
  localparam logic [CW-1:0] CAP  = CW'(HEAP_DEPTH - 1);

  typedef logic signed [kls_pkg::DATA_W-1:0] word_t;

  // All-ones index of the last entry on a level.
  function automatic logic [IW-1:0] level_mask(input logic [LW-1:0] lvl);
    logic [LEVELS:0] m;
    m = ((LEVELS + 1)'(1) << lvl) - 1'b1;
    return m[IW-1:0];
  endfunction

  // Position in heap order of an entry given by level and index on level.
  function automatic logic [PW-1:0] pos_of(input logic [LW-1:0] lvl,
                                           input logic [IW:0]   idx);
    return (PW'(1) << lvl) - PW'(1) + PW'(idx);
  endfunction

  kls_pkg::kls_state_e  state_q, state_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [LW-1:0]        tl_q, tl_d;      // tail slot: first free position
  logic [IW-1:0]        ti_q, ti_d;
  logic [LW-1:0]        cl_q, cl_d;      // hole being moved by a sift
  logic [IW-1:0]        ci_q, ci_d;
  word_t                mv_q, mv_d;      // value looking for its place
  word_t                child_q, child_d;
  word_t                root_q;
  logic [kls_pkg::K_W-1:0] k_q;
  logic                 out_valid_q, out_valid_d;
  word_t                out_data_q, out_data_d;
  logic                 out_hold_q, out_hold_d;

  kls_pkg::kls_req_t    req;
  logic [kls_pkg::DATA_W-1:0] chain_data [LEVELS+1];
  word_t                rd_data;

  logic [CW-1:0]        keep;
  logic [IW:0]          lc_idx;
  logic [IW:0]          rc_idx;
  logic [LW-1:0]        cl_dn;
  logic [PW-1:0]        lc_pos;
  logic [PW-1:0]        rc_pos;
  logic                 lc_ex;
  logic                 rc_ex;
  logic [PW-1:0]        tail_pos;
  logic                 go_l;
  logic                 go_r;
  word_t                best;
  logic                 cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= kls_pkg::K_W'(1);
    end else if (cfg_wr && (paddr[2] == kls_pkg::REG_K_RANK)) begin
      k_q <= pwdata[kls_pkg::K_W-1:0];
    end
  end

  assign prdata = (paddr[2] == kls_pkg::REG_K_RANK) ?
                  kls_pkg::APB_DW'(k_q) : '0;

  // Effective rank: never more than the store can hold minus one.
  always_comb begin
    if (KEW'(k_q) > KEW'(CAP)) begin
      keep = CAP;
    end else begin
      keep = CW'(k_q);
    end
  end

  // ---------------------------------------------------------------------
  // Row of level cells
  // ---------------------------------------------------------------------
  assign chain_data[LEVELS] = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    kls_level_cell #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .LEVEL      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req),
      .rdata_i (chain_data[g+1]),
      .rdata_o (chain_data[g])
    );
  end

  assign rd_data = chain_data[0];

  // ---------------------------------------------------------------------
  // Sift sequencer
  // ---------------------------------------------------------------------
  assign lc_idx   = {ci_q, 1'b0};
  assign rc_idx   = {ci_q, 1'b1};
  assign cl_dn    = cl_q + LW'(1);
  assign lc_pos   = pos_of(cl_dn, lc_idx);
  assign rc_pos   = pos_of(cl_dn, rc_idx);
  assign lc_ex    = lc_pos < PW'(fill_q);
  assign rc_ex    = rc_pos < PW'(fill_q);
  assign tail_pos = pos_of(tl_q, {1'b0, ti_q});

  assign go_l = $signed(child_q) < $signed(mv_q);
  assign best = go_l ? child_q : mv_q;
  assign go_r = $signed(rd_data) < $signed(best);

  assign s_axis_tready = (state_q == kls_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    tl_d        = tl_q;
    ti_d        = ti_q;
    cl_d        = cl_q;
    ci_d        = ci_q;
    mv_d        = mv_q;
    child_d     = child_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_hold_d  = out_hold_q;
    req         = '0;

    // drop the result once the sink takes it
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      kls_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          mv_d = word_t'(s_axis_tdata);
          if (fill_q != FULL) begin
            // open a hole at the tail and advance the tail
            cl_d   = tl_q;
            ci_d   = ti_q;
            fill_d = fill_q + CW'(1);
            if (ti_q == level_mask(tl_q)) begin
              tl_d = tl_q + LW'(1);
              ti_d = '0;
            end else begin
              ti_d = ti_q + IW'(1);
            end
            state_d = kls_pkg::ST_UP;
          end else begin
            state_d = kls_pkg::ST_POP;
          end
        end
      end

      kls_pkg::ST_UP: begin
        if (cl_q == '0) begin
          req.wr_en   = 1'b1;
          req.wr_lvl  = '0;
          req.wr_idx  = '0;
          req.wr_data = mv_q;
          state_d     = kls_pkg::ST_POP;
        end else begin
          req.rd_en  = 1'b1;
          req.rd_lvl = kls_pkg::REQ_LVL_W'(cl_q - LW'(1));
          req.rd_idx = kls_pkg::REQ_IDX_W'(ci_q >> 1);
          state_d    = kls_pkg::ST_UP_WAIT;
        end
      end

      kls_pkg::ST_UP_WAIT: begin
        req.wr_en  = 1'b1;
        req.wr_lvl = kls_pkg::REQ_LVL_W'(cl_q);
        req.wr_idx = kls_pkg::REQ_IDX_W'(ci_q);
        if ($signed(mv_q) < $signed(rd_data)) begin
          // pull the parent down into the hole, climb one level
          req.wr_data = rd_data;
          cl_d        = cl_q - LW'(1);
          ci_d        = ci_q >> 1;
          state_d     = kls_pkg::ST_UP;
        end else begin
          req.wr_data = mv_q;
          state_d     = kls_pkg::ST_POP;
        end
      end

      kls_pkg::ST_POP: begin
        if (fill_q > keep) begin
          // step the tail back and fetch the last entry
          if (ti_q == '0) begin
            tl_d = tl_q - LW'(1);
            ti_d = level_mask(tl_q - LW'(1));
          end else begin
            ti_d = ti_q - IW'(1);
          end
          req.rd_en  = 1'b1;
          req.rd_lvl = kls_pkg::REQ_LVL_W'(tl_d);
          req.rd_idx = kls_pkg::REQ_IDX_W'(ti_d);
          fill_d     = fill_q - CW'(1);
          state_d    = kls_pkg::ST_POP_WAIT;
        end else begin
          state_d = kls_pkg::ST_DONE;
        end
      end

      kls_pkg::ST_POP_WAIT: begin
        mv_d    = rd_data;
        cl_d    = '0;
        ci_d    = '0;
        state_d = kls_pkg::ST_DN;
      end

      kls_pkg::ST_DN: begin
        if (!lc_ex) begin
          req.wr_en   = 1'b1;
          req.wr_lvl  = kls_pkg::REQ_LVL_W'(cl_q);
          req.wr_idx  = kls_pkg::REQ_IDX_W'(ci_q);
          req.wr_data = mv_q;
          state_d     = kls_pkg::ST_DONE;
        end else begin
          req.rd_en  = 1'b1;
          req.rd_lvl = kls_pkg::REQ_LVL_W'(cl_dn);
          req.rd_idx = kls_pkg::REQ_IDX_W'(lc_idx[IW-1:0]);
          state_d    = kls_pkg::ST_DN_L;
        end
      end

      kls_pkg::ST_DN_L: begin
        child_d = rd_data;
        if (rc_ex) begin
          req.rd_en  = 1'b1;
          req.rd_lvl = kls_pkg::REQ_LVL_W'(cl_dn);
          req.rd_idx = kls_pkg::REQ_IDX_W'(rc_idx[IW-1:0]);
          state_d    = kls_pkg::ST_DN_R;
        end else begin
          req.wr_en  = 1'b1;
          req.wr_lvl = kls_pkg::REQ_LVL_W'(cl_q);
          req.wr_idx = kls_pkg::REQ_IDX_W'(ci_q);
          if ($signed(rd_data) < $signed(mv_q)) begin
            req.wr_data = rd_data;
            cl_d        = cl_dn;
            ci_d        = lc_idx[IW-1:0];
            state_d     = kls_pkg::ST_DN;
          end else begin
            req.wr_data = mv_q;
            state_d     = kls_pkg::ST_DONE;
          end
        end
      end

      kls_pkg::ST_DN_R: begin
        req.wr_en  = 1'b1;
        req.wr_lvl = kls_pkg::REQ_LVL_W'(cl_q);
        req.wr_idx = kls_pkg::REQ_IDX_W'(ci_q);
        if (go_r) begin
          req.wr_data = rd_data;
          cl_d        = cl_dn;
          ci_d        = rc_idx[IW-1:0];
          state_d     = kls_pkg::ST_DN;
        end else if (go_l) begin
          req.wr_data = child_q;
          cl_d        = cl_dn;
          ci_d        = lc_idx[IW-1:0];
          state_d     = kls_pkg::ST_DN;
        end else begin
          req.wr_data = mv_q;
          state_d     = kls_pkg::ST_DONE;
        end
      end

      kls_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = (fill_q == '0) ? '0 : root_q;
          out_hold_d  = (fill_q != '0) && (fill_q >= keep);
          state_d     = kls_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kls_pkg::ST_IDLE;
      fill_q      <= '0;
      tl_q        <= '0;
      ti_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      tl_q        <= tl_d;
      ti_q        <= ti_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; the root copy mirrors every write to level zero.
  always_ff @(posedge clk_i) begin
    cl_q       <= cl_d;
    ci_q       <= ci_d;
    mv_q       <= mv_d;
    child_q    <= child_d;
    out_data_q <= out_data_d;
    out_hold_q <= out_hold_d;
    if (req.wr_en && (req.wr_lvl == '0)) begin
      root_q <= req.wr_data;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_hold_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tail_tracks_fill : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    tail_pos == PW'(fill_q)
  ) else $error("tail slot out of step with fill count");

  a_accept_leaves_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != kls_pkg::ST_IDLE)
  ) else $error("accepted transfer did not start a heap update");

  a_hole_in_tree : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == kls_pkg::ST_DN) |-> (cl_q < LW'(LEVELS))
  ) else $error("sift-down hole beyond the deepest level");

  a_done_within_cap : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == kls_pkg::ST_DONE) |-> (fill_q != FULL)
  ) else $error("heap left full after an update");

endmodule
